// ===== src/pct_pkg.sv =====
package pct_pkg;

  // result kinds
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // record type codes
  localparam logic [7:0] TYPE_ROOT    = 8'd1;
  localparam logic [7:0] TYPE_PARENT  = 8'd3;
  localparam logic [7:0] TYPE_CURRENT = 8'd4;
  localparam logic [7:0] TYPE_NAME    = 8'd5;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int RES_MAX = 4;  // most results one byte can cause
  localparam int CNT_W   = 3;  // holds 0..RES_MAX
  localparam int LEN_W   = 13;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       ch;
    logic [LEN_W-1:0] len;
    logic             fin;
  } res_t;

endpackage

// ===== src/pct_in_if.sv =====
interface pct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

// ===== src/pct_out_if.sv =====
interface pct_out_if import pct_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       out_kind;
  logic [7:0]       out_char;
  logic [LEN_W-1:0] out_length;
  logic             out_final;

  modport source(output valid, out_kind, out_char, out_length, out_final, input ready);
  modport sink(input valid, out_kind, out_char, out_length, out_final, output ready);
endinterface

// ===== src/pct_step.sv =====
module pct_step import pct_pkg::*; #(
  parameter int HEADER_BYTES   = 4,
  parameter int MAX_BODY_BYTES = 4096,
  localparam int HP_W = $clog2(HEADER_BYTES),
  localparam int TL_W = $clog2(MAX_BODY_BYTES + 1)
) (
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic [HP_W-1:0] hp,
  input  logic [7:0]      rk,
  input  logic [7:0]      ir,
  input  logic [7:0]      hc,
  input  logic            hv,
  input  logic [TL_W-1:0] tl,
  output logic [HP_W-1:0] hp_out,
  output logic [7:0]      rk_out,
  output logic [7:0]      ir_out,
  output logic [7:0]      hc_out,
  output logic            hv_out,
  output logic [TL_W-1:0] tl_out,
  output res_t            res [RES_MAX],
  output logic [CNT_W-1:0] res_cnt
);

  logic [HP_W-1:0]  hp_v;
  logic [7:0]       rk_v;
  logic [7:0]       ir_v;
  logic [7:0]       hc_v;
  logic             hv_v;
  logic [TL_W-1:0]  tl_v;
  logic             restart;
  logic [1:0]       push_n;
  logic [7:0]       push_c [3];
  logic [CNT_W-1:0] n;

  always_comb begin
    hp_v    = hp;
    rk_v    = rk;
    ir_v    = ir;
    hc_v    = hc;
    hv_v    = hv;
    tl_v    = tl;
    restart = 1'b0;
    push_n  = 2'd0;
    push_c  = '{default: 8'h00};
    n       = '0;
    res     = '{default: '0};

    if (hp == '0 && ir != 8'd0) begin
      // identifier byte
      ir_v = ir - 8'd1;
      if (rk == TYPE_NAME) begin
        push_c[0] = in_byte;
        if (ir_v == 8'd0) begin
          push_c[1] = CH_SLASH;
          push_n    = 2'd2;
        end else begin
          push_n = 2'd1;
        end
      end
    end else begin
      if (hp == '0) begin
        rk_v = in_byte;
      end else if (hp == HP_W'(1)) begin
        ir_v = in_byte;
      end
      if (hp == HP_W'(HEADER_BYTES - 1)) begin
        hp_v = '0;
        if (rk_v == TYPE_ROOT && ir_v == 8'd0) begin
          restart   = 1'b1;
          push_c[0] = CH_SLASH;
          push_n    = 2'd1;
        end else if (rk_v == TYPE_PARENT) begin
          push_c[0] = CH_DOT;
          push_c[1] = CH_DOT;
          push_c[2] = CH_SLASH;
          push_n    = 2'd3;
        end else if (rk_v == TYPE_CURRENT) begin
          push_c[0] = CH_DOT;
          push_c[1] = CH_SLASH;
          push_n    = 2'd2;
        end else if (rk_v == TYPE_NAME && ir_v == 8'd0) begin
          push_c[0] = CH_SLASH;
          push_n    = 2'd1;
        end
      end else begin
        hp_v = hp + HP_W'(1);
      end
    end

    if (restart) begin
      res[n[1:0]].kind = KIND_RESTART;
      n    = n + CNT_W'(1);
      hv_v = 1'b0;
      tl_v = '0;
    end

    // each push releases the previously held character, if one is held
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n) begin
        if (hv_v) begin
          res[n[1:0]].kind = KIND_CHAR;
          res[n[1:0]].ch   = hc_v;
          n = n + CNT_W'(1);
          if (tl_v < TL_W'(MAX_BODY_BYTES)) begin
            tl_v = tl_v + TL_W'(1);
          end
        end
        hc_v = push_c[i];
        hv_v = 1'b1;
      end
    end

    if (in_last) begin
      res[n[1:0]].kind = KIND_END;
      res[n[1:0]].len  = LEN_W'(tl_v);
      n    = n + CNT_W'(1);
      hp_v = '0;
      rk_v = 8'd0;
      ir_v = 8'd0;
      hc_v = 8'd0;
      hv_v = 1'b0;
      tl_v = '0;
    end

    if (n != '0) begin
      res[n[1:0] - 2'd1].fin = 1'b1;
    end

    hp_out  = hp_v;
    rk_out  = rk_v;
    ir_out  = ir_v;
    hc_out  = hc_v;
    hv_out  = hv_v;
    tl_out  = tl_v;
    res_cnt = n;
  end

endmodule

// ===== src/path_component_to_text_core.sv =====
// Channel   Dir  Payload                                    Handshake
// in_ch     in   in_byte[7:0], in_last                      valid/ready
// out_ch    out  out_kind[1:0], out_char[7:0],              valid/ready
//                out_length[12:0], out_final
//
// A byte causing zero or one result is taken every cycle unless out_ch stalls.
// A byte causing k results (k up to 4) holds in_ch.ready low while the result
// queue drains to out_ch, one entry per cycle while out_ch.ready is high.
// Results appear in the cycle after the byte is taken.
// rst_n (synchronous) clears the parser state and empties the result queue.
// out_ch stalls hold the queue head; input waits until the queue drains.
module path_component_to_text_core import pct_pkg::*; #(
  parameter int HEADER_BYTES   = 4,
  parameter int MAX_BODY_BYTES = 4096
) (
  input logic       clk,
  input logic       rst_n,
  pct_in_if.sink    in_ch,
  pct_out_if.source out_ch
);

  localparam int HP_W = $clog2(HEADER_BYTES);
  localparam int TL_W = $clog2(MAX_BODY_BYTES + 1);

  logic [HP_W-1:0]  hp_r, hp_nxt;
  logic [7:0]       rk_r, rk_nxt;
  logic [7:0]       ir_r, ir_nxt;
  logic [7:0]       hc_r, hc_nxt;
  logic             hv_r, hv_nxt;
  logic [TL_W-1:0]  tl_r, tl_nxt;

  res_t             q_r [RES_MAX];
  res_t             q_nxt [RES_MAX];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  res_t             res [RES_MAX];
  logic [CNT_W-1:0] res_cnt;

  logic in_acc;
  logic out_acc;

  pct_step #(
    .HEADER_BYTES  (HEADER_BYTES),
    .MAX_BODY_BYTES(MAX_BODY_BYTES)
  ) u_step (
    .in_byte(in_ch.in_byte),
    .in_last(in_ch.in_last),
    .hp     (hp_r),
    .rk     (rk_r),
    .ir     (ir_r),
    .hc     (hc_r),
    .hv     (hv_r),
    .tl     (tl_r),
    .hp_out (hp_nxt),
    .rk_out (rk_nxt),
    .ir_out (ir_nxt),
    .hc_out (hc_nxt),
    .hv_out (hv_nxt),
    .tl_out (tl_nxt),
    .res    (res),
    .res_cnt(res_cnt)
  );

  // take a new request once the queue is empty or its last entry leaves now
  assign in_ch.ready = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.out_kind   = q_r[0].kind;
  assign out_ch.out_char   = q_r[0].ch;
  assign out_ch.out_length = q_r[0].len;
  assign out_ch.out_final  = q_r[0].fin;

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      q_nxt   = res;
      cnt_nxt = res_cnt;
    end else if (out_acc) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r  <= '0;
      rk_r  <= 8'd0;
      ir_r  <= 8'd0;
      hc_r  <= 8'd0;
      hv_r  <= 1'b0;
      tl_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_acc) begin
        hp_r <= hp_nxt;
        rk_r <= rk_nxt;
        ir_r <= ir_nxt;
        hc_r <= hc_nxt;
        hv_r <= hv_nxt;
        tl_r <= tl_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RES_MAX))
    else $error("result queue count out of range");

  a_fin_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.out_final |-> cnt_r > CNT_W'(1))
    else $error("non-final result at queue tail");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.in_last |=> hp_r == '0 && ir_r == 8'd0 && !hv_r && tl_r == '0)
    else $error("state not cleared after end of body");

  a_kind_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_kind != KIND_CHAR |-> out_ch.out_char == 8'd0)
    else $error("character on non-text result");

  a_kind_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_kind != KIND_END |-> out_ch.out_length == '0)
    else $error("length on non-end result");

endmodule
